// ===== src/dwfz_pkg.sv =====
// ----------------------------------------------------------------------------
// dwfz_pkg - shared types for the DHWNC to fractal-Z-3D address generator
// Register indexes, clamped configuration bundle and the job record passed
// from the walker to the offset pipeline.
// ----------------------------------------------------------------------------
package dwfz_pkg;

  // field widths
  localparam int unsigned CfgW   = 13;  // size registers
  localparam int unsigned LaneW  = 6;   // lane register and lane counter
  localparam int unsigned EbW    = 4;   // element size register
  localparam int unsigned IdxW   = 13;  // d, h, w, group, n and c indexes
  localparam int unsigned CIdxW  = 14;  // padded C index (padding may pass 8191)
  localparam int unsigned OffW   = 40;  // byte offsets and element counter
  localparam int unsigned QDepth = 4;   // walker to pipeline queue depth
  localparam int unsigned QPtrW  = 2;

  // largest legal value of the lane and element size registers
  localparam logic [LaneW-1:0] LaneMax = 6'd32;
  localparam logic [EbW-1:0]   EbMax   = 4'd8;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEPTH_D       = 3'd0,
    REG_HEIGHT_H      = 3'd1,
    REG_WIDTH_W       = 3'd2,
    REG_COUNT_N       = 3'd3,
    REG_COUNT_C       = 3'd4,
    REG_LANE_C0       = 3'd5,
    REG_ELEMENT_BYTES = 3'd6
  } cfg_reg_e;

  // configuration after saturation
  typedef struct packed {
    logic [CfgW-1:0]  dd;
    logic [CfgW-1:0]  hh;
    logic [CfgW-1:0]  ww;
    logic [CfgW-1:0]  nn;
    logic [CfgW-1:0]  cc;
    logic [LaneW-1:0] c0;
    logic [EbW-1:0]   eb;
  } cfg_t;

  // one destination element to resolve
  typedef struct packed {
    logic [IdxW-1:0] d;
    logic [IdxW-1:0] h;
    logic [IdxW-1:0] w;
    logic [IdxW-1:0] nidx;
    logic [IdxW-1:0] cidx;
    logic [OffW-1:0] dst;
    logic            pad;
    logic            last;
  } job_t;

endpackage

// ===== src/dhwnc_to_fractal_z3d_address_gen.sv =====
// ----------------------------------------------------------------------------
// dhwnc_to_fractal_z3d_address_gen - layout copy address generator
// Walks the fractal-Z-3D destination and gives byte offsets per element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat per tick. restart 1
//   opens a new pass at element zero, restart 0 steps to the next element.
//   A beat with no pass open, or with any size register zero, gives nothing.
//   Output channel (out_valid_o / out_stall_i): destination offset, source
//   offset (zero on padding), pad and last marks per element.
//   Throughput: one beat per cycle while no stall is held; the walker
//   classifies a beat in the cycle it is taken, and a four-entry queue
//   feeds a five-stage offset pipeline that spreads the multiplies over
//   its stages. A taken beat goes through the queue and then the stages.
//   Stalls: out_stall_i holds the pipeline; once it and the queue fill,
//   in_stall_o rises. Configuration writes go through cfg_we_i; the user
//   makes them only while idle, the block itself does not enforce it.
//   Reset: sizes 1, lane 16, two bytes per element, no pass open.
// ----------------------------------------------------------------------------
module dhwnc_to_fractal_z3d_address_gen #(
  parameter int unsigned NI_SIZE = 16,
  parameter int unsigned DIM_MAX = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [dwfz_pkg::CfgW-1:0]     cfg_data_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_restart_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dwfz_pkg::OffW-1:0]     out_dst_byte_o,
  output logic [dwfz_pkg::OffW-1:0]     out_src_offset_o,
  output logic                          out_pad_o,
  output logic                          out_last_o
);

  localparam int unsigned DimCap = (DIM_MAX > 8191) ? 8191 : DIM_MAX;
  localparam logic [dwfz_pkg::CfgW-1:0] DimTop = dwfz_pkg::CfgW'(DimCap);

  logic [dwfz_pkg::CfgW-1:0]  dd_q, hh_q, ww_q, nn_q, cc_q;
  logic [dwfz_pkg::LaneW-1:0] c0_q;
  logic [dwfz_pkg::EbW-1:0]   eb_q;
  dwfz_pkg::cfg_t             cfg;
  dwfz_pkg::job_t             push_job, pop_job;
  logic                       take, push, pop, q_valid, q_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dd_q <= 13'd1;
      hh_q <= 13'd1;
      ww_q <= 13'd1;
      nn_q <= 13'd1;
      cc_q <= 13'd1;
      c0_q <= 6'd16;
      eb_q <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dwfz_pkg::REG_DEPTH_D:       dd_q <= cfg_data_i;
        dwfz_pkg::REG_HEIGHT_H:      hh_q <= cfg_data_i;
        dwfz_pkg::REG_WIDTH_W:       ww_q <= cfg_data_i;
        dwfz_pkg::REG_COUNT_N:       nn_q <= cfg_data_i;
        dwfz_pkg::REG_COUNT_C:       cc_q <= cfg_data_i;
        dwfz_pkg::REG_LANE_C0:       c0_q <= cfg_data_i[dwfz_pkg::LaneW-1:0];
        dwfz_pkg::REG_ELEMENT_BYTES: eb_q <= cfg_data_i[dwfz_pkg::EbW-1:0];
        default: ;
      endcase
    end
  end

  // saturate to legal ranges
  assign cfg.dd = (dd_q > DimTop) ? DimTop : dd_q;
  assign cfg.hh = (hh_q > DimTop) ? DimTop : hh_q;
  assign cfg.ww = (ww_q > DimTop) ? DimTop : ww_q;
  assign cfg.nn = (nn_q > DimTop) ? DimTop : nn_q;
  assign cfg.cc = (cc_q > DimTop) ? DimTop : cc_q;
  assign cfg.c0 = (c0_q > dwfz_pkg::LaneMax) ? dwfz_pkg::LaneMax : c0_q;
  assign cfg.eb = (eb_q > dwfz_pkg::EbMax) ? dwfz_pkg::EbMax : eb_q;

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  dwfz_front #(
    .NI_SIZE (NI_SIZE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .take_i    (take),
    .restart_i (in_restart_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  dwfz_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .job_o   (pop_job)
  );

  dwfz_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .job_valid_i  (q_valid),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dst_byte_o   (out_dst_byte_o),
    .src_offset_o (out_src_offset_o),
    .pad_o        (out_pad_o),
    .last_o       (out_last_o)
  );

endmodule

// ===== src/dwfz_front.sv =====
// ----------------------------------------------------------------------------
// dwfz_front - destination walker
// Holds the nested element counters, classifies each beat (restart, empty,
// no pass, padding, last) and pushes one job per emitted element.
// ----------------------------------------------------------------------------
module dwfz_front #(
  parameter int unsigned NI_SIZE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dwfz_pkg::cfg_t                cfg_i,
  input  logic                          take_i,     // beat accepted
  input  logic                          restart_i,
  output logic                          push_o,
  output dwfz_pkg::job_t                job_o
);

  localparam int unsigned SubW = (NI_SIZE > 1) ? $clog2(NI_SIZE) : 1;
  localparam logic [SubW-1:0] SubLast = SubW'(NI_SIZE - 1);
  localparam logic [dwfz_pkg::CIdxW-1:0] CStep = dwfz_pkg::CIdxW'(NI_SIZE);

  logic [dwfz_pkg::IdxW-1:0]  d_q, d_d, h_q, h_d, w_q, w_d, g_q, g_d;
  logic [dwfz_pkg::CIdxW-1:0] cb_q, cb_d;   // padded C index rounded down to NI
  logic [SubW-1:0]            cs_q, cs_d;   // padded C index within NI block
  logic [dwfz_pkg::LaneW-1:0] lane_q, lane_d;
  logic [dwfz_pkg::OffW-1:0]  dst_q, dst_d;
  logic                       done_q, done_d;

  logic [dwfz_pkg::IdxW-1:0]  d_c, h_c, w_c, g_c;
  logic [dwfz_pkg::CIdxW-1:0] cb_c, cidx;
  logic [SubW-1:0]            cs_c;
  logic [dwfz_pkg::LaneW-1:0] lane_c;
  logic [dwfz_pkg::OffW-1:0]  dst_c;
  logic                       done_c;
  logic [18:0]                gbase;
  logic [19:0]                nidx;
  logic                       empty, emit, pad, last;
  logic                       lane_end, c_end, w_end, h_end, g_end, d_end;

  // restart clears the pass before the beat is classified
  always_comb begin
    d_c    = restart_i ? '0 : d_q;
    h_c    = restart_i ? '0 : h_q;
    w_c    = restart_i ? '0 : w_q;
    g_c    = restart_i ? '0 : g_q;
    cb_c   = restart_i ? '0 : cb_q;
    cs_c   = restart_i ? '0 : cs_q;
    lane_c = restart_i ? '0 : lane_q;
    dst_c  = restart_i ? '0 : dst_q;
    done_c = restart_i ? 1'b0 : done_q;
  end

  assign empty = (cfg_i.dd == '0) || (cfg_i.hh == '0) || (cfg_i.ww == '0) ||
                 (cfg_i.nn == '0) || (cfg_i.cc == '0) || (cfg_i.c0 == '0) ||
                 (cfg_i.eb == '0);
  assign emit  = !empty && !done_c;

  // element classification
  assign gbase = g_c * cfg_i.c0;
  assign nidx  = 20'(gbase) + 20'(lane_c);
  assign cidx  = cb_c + dwfz_pkg::CIdxW'(cs_c);
  assign pad   = (nidx >= 20'(cfg_i.nn)) || (cidx >= dwfz_pkg::CIdxW'(cfg_i.cc));

  // end of each loop level: index + 1 reaches its bound
  assign lane_end = (7'(lane_c) + 7'd1) >= 7'(cfg_i.c0);
  assign c_end    = (15'(cb_c) >= 15'(cfg_i.cc)) ||
                    ((cs_c == SubLast) && ((15'(cb_c) + 15'(CStep)) >= 15'(cfg_i.cc)));
  assign w_end    = (14'(w_c) + 14'd1) >= 14'(cfg_i.ww);
  assign h_end    = (14'(h_c) + 14'd1) >= 14'(cfg_i.hh);
  assign g_end    = (20'(gbase) + 20'(cfg_i.c0)) >= 20'(cfg_i.nn);
  assign d_end    = (14'(d_c) + 14'd1) >= 14'(cfg_i.dd);
  assign last     = lane_end && c_end && w_end && h_end && g_end && d_end;

  // next counter state
  always_comb begin
    d_d = d_c; h_d = h_c; w_d = w_c; g_d = g_c;
    cb_d = cb_c; cs_d = cs_c; lane_d = lane_c; dst_d = dst_c;
    done_d = done_c;
    if (empty) begin
      done_d = 1'b1;
    end else if (emit && last) begin
      done_d = 1'b1;
    end else if (emit) begin
      dst_d = dst_c + 1'b1;
      if (!lane_end) begin
        lane_d = lane_c + 1'b1;
      end else begin
        lane_d = '0;
        if (!c_end) begin
          if (cs_c == SubLast) begin
            cs_d = '0;
            cb_d = cb_c + CStep;
          end else begin
            cs_d = cs_c + 1'b1;
          end
        end else begin
          cs_d = '0;
          cb_d = '0;
          if (!w_end) begin
            w_d = w_c + 1'b1;
          end else begin
            w_d = '0;
            if (!h_end) begin
              h_d = h_c + 1'b1;
            end else begin
              h_d = '0;
              if (!g_end) begin
                g_d = g_c + 1'b1;
              end else begin
                g_d = '0;
                d_d = d_end ? '0 : d_c + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q    <= '0;
      h_q    <= '0;
      w_q    <= '0;
      g_q    <= '0;
      cb_q   <= '0;
      cs_q   <= '0;
      lane_q <= '0;
      dst_q  <= '0;
      done_q <= 1'b1;
    end else if (take_i) begin
      d_q    <= d_d;
      h_q    <= h_d;
      w_q    <= w_d;
      g_q    <= g_d;
      cb_q   <= cb_d;
      cs_q   <= cs_d;
      lane_q <= lane_d;
      dst_q  <= dst_d;
      done_q <= done_d;
    end
  end

  // job record; n and c indexes only matter when not padding
  assign push_o      = take_i && emit;
  assign job_o.d     = d_c;
  assign job_o.h     = h_c;
  assign job_o.w     = w_c;
  assign job_o.nidx  = nidx[dwfz_pkg::IdxW-1:0];
  assign job_o.cidx  = cidx[dwfz_pkg::IdxW-1:0];
  assign job_o.dst   = dst_c;
  assign job_o.pad   = pad;
  assign job_o.last  = last;

endmodule

// ===== src/dwfz_queue.sv =====
// ----------------------------------------------------------------------------
// dwfz_queue - short job queue
// Decouples the walker from the offset pipeline; full stalls the input side.
// ----------------------------------------------------------------------------
module dwfz_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dwfz_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output dwfz_pkg::job_t job_o
);

  dwfz_pkg::job_t              slot_q [dwfz_pkg::QDepth];
  logic [dwfz_pkg::QPtrW-1:0]  wptr_q, rptr_q;
  logic [dwfz_pkg::QPtrW:0]    cnt_q;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (dwfz_pkg::QPtrW + 1)'(dwfz_pkg::QDepth));
  assign job_o   = slot_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/dwfz_back.sv =====
// ----------------------------------------------------------------------------
// dwfz_back - offset pipeline
// Five stages turn a job's indexes into destination and source byte offsets.
// Each stage moves when the next one is free or moving; the last stage is
// the output register.
// ----------------------------------------------------------------------------
module dwfz_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dwfz_pkg::cfg_t            cfg_i,
  input  logic                      job_valid_i,
  input  dwfz_pkg::job_t            job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dwfz_pkg::OffW-1:0] dst_byte_o,
  output logic [dwfz_pkg::OffW-1:0] src_offset_o,
  output logic                      pad_o,
  output logic                      last_o
);

  localparam int unsigned OffW = dwfz_pkg::OffW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;

  logic [26:0]     a1_q, p1_q, p2_q, p3_q;
  logic [25:0]     nc1_q, nc2_q;
  logic [12:0]     w1_q;
  logic [OffW-1:0] dst1_q, dst2_q, dst3_q, dst4_q;
  logic            pad1_q, pad2_q, pad3_q, pad4_q;
  logic            last1_q, last2_q, last3_q, last4_q;
  logic [OffW-1:0] b2_q, sum4_q;
  logic [45:0]     plo3_q;
  logic [19:0]     phi3_q;
  logic [OffW-1:0] dst5_q, src5_q;
  logic            pad5_q, last5_q;

  logic [25:0]     dh_mul, nc_mul, nc_c;
  logic [26:0]     a_sum, p_sum;
  logic [43:0]     dst_mul, src_mul;
  logic [39:0]     aw_mul, phi_mul;
  logic [45:0]     plo_mul;

  // stage advance chain from the output back
  assign adv5  = !v5_q || !out_stall_i;
  assign adv4  = !v4_q || adv5;
  assign adv3  = !v3_q || adv4;
  assign adv2  = !v2_q || adv3;
  assign adv1  = !v1_q || adv2;
  assign pop_o = job_valid_i && adv1;

  // stage arithmetic
  assign dh_mul  = job_i.d * cfg_i.hh;
  assign a_sum   = 27'(dh_mul) + 27'(job_i.h);
  assign nc_c    = job_i.nidx * cfg_i.cc;
  assign p_sum   = 27'(nc_c) + 27'(job_i.cidx);
  assign nc_mul  = cfg_i.nn * cfg_i.cc;
  assign dst_mul = job_i.dst * cfg_i.eb;
  assign aw_mul  = a1_q * cfg_i.ww;
  assign plo_mul = b2_q[19:0] * nc2_q;
  assign phi_mul = b2_q[39:20] * nc2_q[19:0];
  assign src_mul = sum4_q * cfg_i.eb;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= job_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    // stage 1: d*H+h, nidx*C+cidx, N*C, destination bytes
    if (adv1) begin
      a1_q    <= a_sum;
      p1_q    <= p_sum;
      nc1_q   <= nc_mul;
      w1_q    <= job_i.w;
      dst1_q  <= dst_mul[OffW-1:0];
      pad1_q  <= job_i.pad;
      last1_q <= job_i.last;
    end
    // stage 2: spatial index (d*H+h)*W+w
    if (adv2) begin
      b2_q    <= aw_mul + OffW'(w1_q);
      p2_q    <= p1_q;
      nc2_q   <= nc1_q;
      dst2_q  <= dst1_q;
      pad2_q  <= pad1_q;
      last2_q <= last1_q;
    end
    // stage 3: partial products of spatial index times N*C
    if (adv3) begin
      plo3_q  <= plo_mul;
      phi3_q  <= phi_mul[19:0];
      p3_q    <= p2_q;
      dst3_q  <= dst2_q;
      pad3_q  <= pad2_q;
      last3_q <= last2_q;
    end
    // stage 4: source element index modulo 2^40
    if (adv4) begin
      sum4_q  <= plo3_q[OffW-1:0] + {phi3_q, 20'd0} + OffW'(p3_q);
      dst4_q  <= dst3_q;
      pad4_q  <= pad3_q;
      last4_q <= last3_q;
    end
    // stage 5: output register, source bytes
    if (adv5) begin
      dst5_q  <= dst4_q;
      src5_q  <= pad4_q ? '0 : src_mul[OffW-1:0];
      pad5_q  <= pad4_q;
      last5_q <= last4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign dst_byte_o   = dst5_q;
  assign src_offset_o = src5_q;
  assign pad_o        = pad5_q;
  assign last_o       = last5_q;

endmodule
